/* design/fvnh_pkg.sv */
// Shared types and constants for the fractal value noise height map block.
// No dependencies; every other file imports this package.
package fvnh_pkg;

    // grid geometry and sample format
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int SMP_W     = 16;
    localparam int DIM_W     = 7;
    localparam int OCT_W     = 4;
    localparam int K_W       = 3;

    localparam logic [DIM_W-1:0] MAX_ROWS = 7'd64;
    localparam logic [DIM_W-1:0] MAX_COLS = 7'd64;
    localparam logic [OCT_W-1:0] MAX_OCT  = 4'd8;

    // remainder unit: dividend below 2*64 + 64, divisor 1..64
    localparam int NUM_W  = 8;
    localparam int DEN_W  = DIM_W;
    localparam int RSTP_W = 3;

    // accumulation and final divide
    localparam int SUM_W  = 35;
    localparam int TOT_W  = 19;
    localparam int QUO_W  = 16;
    localparam int DSTP_W = 4;

    // shared multiplier: 17 x 17 signed
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REGI_W  = 3;

    localparam logic [REGI_W-1:0] REG_ROWS = 3'd0;
    localparam logic [REGI_W-1:0] REG_COLS = 3'd1;
    localparam logic [REGI_W-1:0] REG_OCTS = 3'd2;
    localparam logic [REGI_W-1:0] REG_PERS = 3'd3;
    localparam logic [REGI_W-1:0] REG_HMIN = 3'd4;
    localparam logic [REGI_W-1:0] REG_HMAX = 3'd5;

    localparam logic [DIM_W-1:0] RST_ROWS = 7'd64;
    localparam logic [DIM_W-1:0] RST_COLS = 7'd64;
    localparam logic [OCT_W-1:0] RST_OCTS = 4'd5;
    localparam logic [15:0]      RST_PERS = 16'd26214;
    localparam logic [15:0]      RST_HMIN = 16'd0;
    localparam logic [15:0]      RST_HMAX = 16'd65535;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [OCT_W-1:0] octs;
        logic [15:0]      pers;
        logic [15:0]      hmin;
        logic [15:0]      hmax;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] a_num;
        logic [DEN_W-1:0] a_den;
        logic [NUM_W-1:0] b_num;
        logic [DEN_W-1:0] b_den;
    } t_rem_req;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [TOT_W-1:0] den;
    } t_div_req;

endpackage

/* design/fvnh_regs.sv */
// APB-style configuration registers of the noise height map block.
// Depends on fvnh_pkg for register codes, reset values and t_cfg.
module fvnh_regs import fvnh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg              r_cfg;
    logic [REGI_W-1:0] w_idx;
    logic              w_wr;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= RST_ROWS;
            r_cfg.cols <= RST_COLS;
            r_cfg.octs <= RST_OCTS;
            r_cfg.pers <= RST_PERS;
            r_cfg.hmin <= RST_HMIN;
            r_cfg.hmax <= RST_HMAX;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROWS: r_cfg.rows <= pwdata[DIM_W-1:0];
                REG_COLS: r_cfg.cols <= pwdata[DIM_W-1:0];
                REG_OCTS: r_cfg.octs <= pwdata[OCT_W-1:0];
                REG_PERS: r_cfg.pers <= pwdata[15:0];
                REG_HMIN: r_cfg.hmin <= pwdata[15:0];
                REG_HMAX: r_cfg.hmax <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROWS: prdata = {{(PDATA_W-DIM_W){1'b0}}, r_cfg.rows};
            REG_COLS: prdata = {{(PDATA_W-DIM_W){1'b0}}, r_cfg.cols};
            REG_OCTS: prdata = {{(PDATA_W-OCT_W){1'b0}}, r_cfg.octs};
            REG_PERS: prdata = {16'h0000, r_cfg.pers};
            REG_HMIN: prdata = {16'h0000, r_cfg.hmin};
            REG_HMAX: prdata = {16'h0000, r_cfg.hmax};
            default:  prdata = '0;
        endcase
    end

endmodule

/* design/fvnh_mem.sv */
// Base noise sample memory: one write port, one read port, registered read data.
// Depends on fvnh_pkg for address and sample widths.
module fvnh_mem import fvnh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [SMP_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [SMP_W-1:0]  o_rdata
);

    logic [SMP_W-1:0] r_mem [MEM_DEPTH];
    logic [SMP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fvnh_rem.sv */
// Two-lane restoring remainder unit for row and column wrap, one quotient bit per cycle.
// Depends on fvnh_pkg for t_rem_req and lane widths.
module fvnh_rem import fvnh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rem_req         i_req,
    output logic             o_done,
    output logic [ROW_W-1:0] o_rem_a,
    output logic [COL_W-1:0] o_rem_b
);

    logic [NUM_W-1:0]       r_rem  [2];
    logic [DEN_W-1:0]       r_den  [2];
    logic [NUM_W-1:0]       w_next [2];
    logic [NUM_W+DEN_W-1:0] w_cand [2];
    logic [RSTP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_cand[l] = {{NUM_W{1'b0}}, r_den[l]} << r_step;
            if ({{DEN_W{1'b0}}, r_rem[l]} >= w_cand[l]) begin
                w_next[l] = r_rem[l] - w_cand[l][NUM_W-1:0];
            end else begin
                w_next[l] = r_rem[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '1;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem[0] <= i_req.a_num;
            r_den[0] <= i_req.a_den;
            r_rem[1] <= i_req.b_num;
            r_den[1] <= i_req.b_den;
        end else if (r_busy) begin
            r_rem[0] <= w_next[0];
            r_rem[1] <= w_next[1];
        end
    end

    assign o_done  = r_done;
    assign o_rem_a = r_rem[0][ROW_W-1:0];
    assign o_rem_b = r_rem[1][COL_W-1:0];

endmodule

/* design/fvnh_div.sv */
// Restoring divider for the weighted noise sum, one quotient bit per cycle.
// Depends on fvnh_pkg for t_div_req and the sum, weight and quotient widths.
module fvnh_div import fvnh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    logic [SUM_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quot;
    logic [SUM_W-1:0]  w_cand;
    logic              w_take;
    logic [DSTP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    // quotient fits in QUO_W bits since the sum never exceeds 65535 times the weight
    assign w_cand = {{(SUM_W-TOT_W){1'b0}}, r_den} << r_step;
    // zero weight gives zero noise
    assign w_take = (r_rem >= w_cand) && (r_den != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '1;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_take) begin
                r_rem <= r_rem - w_cand;
            end
            r_quot <= {r_quot[QUO_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/fractal_value_noise_heightmap_top.sv */
// Fractal value noise height map: a load is written to the sample memory when it is
// accepted and leaves the block idle; a read wraps its cell, then for each octave
// runs a remainder pass, four sample memory reads and blends on the shared
// multiplier, then a divide. One read at a time; start is taken again in
// the result strobe cycle. Synchronous reset restores register defaults; samples
// are undefined until loaded. The result strobe cannot be stalled by the receiver.
module fractal_value_noise_heightmap_top import fvnh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_col,
    input  logic [SMP_W-1:0]   i_sample,
    output logic               o_done,
    output logic [15:0]        o_height,
    output logic [ROW_W-1:0]   o_cell_row,
    output logic [COL_W-1:0]   o_cell_col
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WRAP  = 5'd1;
    localparam logic [4:0] S_WGT   = 5'd2;
    localparam logic [4:0] S_OCT   = 5'd3;
    localparam logic [4:0] S_RWAIT = 5'd4;
    localparam logic [4:0] S_RD0   = 5'd5;
    localparam logic [4:0] S_RD1   = 5'd6;
    localparam logic [4:0] S_RD2   = 5'd7;
    localparam logic [4:0] S_RD3   = 5'd8;
    localparam logic [4:0] S_BL0   = 5'd9;
    localparam logic [4:0] S_BL1   = 5'd10;
    localparam logic [4:0] S_BL2   = 5'd11;
    localparam logic [4:0] S_BL3   = 5'd12;
    localparam logic [4:0] S_BL4   = 5'd13;
    localparam logic [4:0] S_ACC   = 5'd14;
    localparam logic [4:0] S_ACC2  = 5'd15;
    localparam logic [4:0] S_DIV0  = 5'd16;
    localparam logic [4:0] S_DWAIT = 5'd17;
    localparam logic [4:0] S_HGT   = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    t_cfg     w_cfg;
    t_rem_req w_rem_req;
    t_div_req w_div_req;

    logic [4:0]  r_state;
    logic [4:0]  n_state;
    logic        r_done;
    logic        w_accept;
    logic        w_load;

    logic [DIM_W-1:0] w_nr;
    logic [DIM_W-1:0] w_nc;
    logic [OCT_W-1:0] w_oc;
    logic [K_W-1:0]   w_k_init;

    logic             w_rem_done;
    logic [ROW_W-1:0] w_rem_a;
    logic [COL_W-1:0] w_rem_b;
    logic             w_div_done;
    logic [QUO_W-1:0] w_quot;

    logic [ADDR_W-1:0] w_raddr;
    logic [SMP_W-1:0]  w_rdata;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_i;
    logic [COL_W-1:0] r_j;
    logic [ROW_W-1:0] r_i0;
    logic [COL_W-1:0] r_j0;
    logic [ROW_W-1:0] r_i1;
    logic [COL_W-1:0] r_j1;
    logic [15:0]      r_th;
    logic [15:0]      r_tv;
    logic [K_W-1:0]   r_k;
    logic             r_first;
    logic [15:0]      r_weight;
    logic [TOT_W-1:0] r_total;
    logic [SUM_W-1:0] r_sum;
    logic [SMP_W-1:0] r_c00;
    logic [SMP_W-1:0] r_c10;
    logic [SMP_W-1:0] r_c01;
    logic [SMP_W-1:0] r_c11;
    logic [15:0]      r_top;
    logic [15:0]      r_bot;
    logic [15:0]      r_v;
    logic [QUO_W-1:0] r_noise;
    logic [15:0]      r_height;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic [15:0]              w_base;
    logic signed [17:0]       w_bsum;
    logic [15:0]              w_blend;
    logic [15:0]              w_eff;

    logic [NUM_W-1:0]   w_mask;
    logic [NUM_W-1:0]   w_per;
    logic [ROW_W-1:0]   w_i0;
    logic [COL_W-1:0]   w_j0;
    logic [ROW_W-1:0]   w_di;
    logic [COL_W-1:0]   w_dj;
    logic [ROW_W+15:0]  w_th_wide;
    logic [COL_W+15:0]  w_tv_wide;

    fvnh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fvnh_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr ({i_row, i_col}),
        .i_wdata (i_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fvnh_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_done  (w_rem_done),
        .o_rem_a (w_rem_a),
        .o_rem_b (w_rem_b)
    );

    fvnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;
    assign w_load   = w_accept & (i_command == CMD_LOAD);

    // clamp the grid size and octave count into range
    assign w_nr = (w_cfg.rows == '0) ? 7'd1 :
                  (w_cfg.rows > MAX_ROWS) ? MAX_ROWS : w_cfg.rows;
    assign w_nc = (w_cfg.cols == '0) ? 7'd1 :
                  (w_cfg.cols > MAX_COLS) ? MAX_COLS : w_cfg.cols;
    assign w_oc = (w_cfg.octs == '0) ? 4'd1 :
                  (w_cfg.octs > MAX_OCT) ? MAX_OCT : w_cfg.octs;
    assign w_k_init = K_W'(w_oc - 4'd1);

    // lattice corner and blend fraction for octave r_k
    assign w_per     = 8'd1 << r_k;
    assign w_mask    = w_per - 8'd1;
    assign w_i0      = r_i & ~w_mask[ROW_W-1:0];
    assign w_j0      = r_j & ~w_mask[COL_W-1:0];
    assign w_di      = r_i & w_mask[ROW_W-1:0];
    assign w_dj      = r_j & w_mask[COL_W-1:0];
    assign w_th_wide = {w_di, 16'h0000} >> r_k;
    assign w_tv_wide = {w_dj, 16'h0000} >> r_k;

    always_comb begin
        w_rem_req.start = (w_accept & (i_command == CMD_READ)) | (r_state == S_OCT);
        w_rem_req.a_den = w_nr;
        w_rem_req.b_den = w_nc;
        if (r_state == S_IDLE) begin
            w_rem_req.a_num = {{(NUM_W-ROW_W){1'b0}}, i_row};
            w_rem_req.b_num = {{(NUM_W-COL_W){1'b0}}, i_col};
        end else begin
            w_rem_req.a_num = {{(NUM_W-ROW_W){1'b0}}, w_i0} + w_per;
            w_rem_req.b_num = {{(NUM_W-COL_W){1'b0}}, w_j0} + w_per;
        end
    end

    always_comb begin
        w_div_req.start = (r_state == S_DIV0);
        w_div_req.num   = r_sum;
        w_div_req.den   = r_total;
    end

    always_comb begin
        case (r_state)
            S_RD1:   w_raddr = {r_i1, r_j0};
            S_RD2:   w_raddr = {r_i0, r_j1};
            S_RD3:   w_raddr = {r_i1, r_j1};
            default: w_raddr = {r_i0, r_j0};
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_WGT: begin
                w_mul_a = {1'b0, r_weight};
                w_mul_b = {1'b0, w_cfg.pers};
            end
            S_BL0: begin
                w_mul_a = {1'b0, r_c10} - {1'b0, r_c00};
                w_mul_b = {1'b0, r_th};
            end
            S_BL1: begin
                w_mul_a = {1'b0, r_c11} - {1'b0, r_c01};
                w_mul_b = {1'b0, r_th};
            end
            S_BL3: begin
                w_mul_a = {1'b0, r_bot} - {1'b0, r_top};
                w_mul_b = {1'b0, r_tv};
            end
            S_ACC: begin
                w_mul_a = {1'b0, r_v};
                w_mul_b = {1'b0, r_weight};
            end
            S_HGT: begin
                w_mul_a = {1'b0, w_cfg.hmax} - {1'b0, w_cfg.hmin};
                w_mul_b = {1'b0, r_noise};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // a + floor((b - a) * t / 2^16), always back in 0..65535
    always_comb begin
        case (r_state)
            S_BL1:   w_base = r_c00;
            S_BL2:   w_base = r_c01;
            S_BL4:   w_base = r_top;
            S_OUT:   w_base = w_cfg.hmin;
            default: w_base = '0;
        endcase
    end
    assign w_bsum  = $signed({2'b00, w_base}) + $signed(r_prod[PROD_W-1:16]);
    assign w_blend = w_bsum[15:0];

    assign w_eff = r_first ? r_weight : r_prod[31:16];

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (w_accept && i_command == CMD_READ) ? S_WRAP : S_IDLE;
            S_WRAP:  n_state = w_rem_done ? S_OCT : S_WRAP;
            S_WGT:   n_state = S_OCT;
            S_OCT:   n_state = S_RWAIT;
            S_RWAIT: n_state = w_rem_done ? S_RD0 : S_RWAIT;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_BL0;
            S_BL0:   n_state = S_BL1;
            S_BL1:   n_state = S_BL2;
            S_BL2:   n_state = S_BL3;
            S_BL3:   n_state = S_BL4;
            S_BL4:   n_state = S_ACC;
            S_ACC:   n_state = S_ACC2;
            S_ACC2:  n_state = (r_k == '0) ? S_DIV0 : S_WGT;
            S_DIV0:  n_state = S_DWAIT;
            S_DWAIT: n_state = w_div_done ? S_HGT : S_DWAIT;
            S_HGT:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_row <= i_row;
                    r_col <= i_col;
                end
            end
            S_WRAP: begin
                if (w_rem_done) begin
                    r_i      <= w_rem_a;
                    r_j      <= w_rem_b;
                    r_weight <= w_cfg.pers;
                    r_total  <= '0;
                    r_sum    <= '0;
                    r_first  <= 1'b1;
                    r_k      <= w_k_init;
                end
            end
            S_OCT: begin
                r_i0     <= w_i0;
                r_j0     <= w_j0;
                r_th     <= w_th_wide[15:0];
                r_tv     <= w_tv_wide[15:0];
                r_weight <= w_eff;
                r_total  <= r_total + {{(TOT_W-16){1'b0}}, w_eff};
            end
            S_RWAIT: begin
                if (w_rem_done) begin
                    r_i1 <= w_rem_a;
                    r_j1 <= w_rem_b;
                end
            end
            S_RD1: r_c00 <= w_rdata;
            S_RD2: r_c10 <= w_rdata;
            S_RD3: r_c01 <= w_rdata;
            S_BL0: r_c11 <= w_rdata;
            S_BL1: r_top <= w_blend;
            S_BL2: r_bot <= w_blend;
            S_BL4: r_v   <= w_blend;
            S_ACC2: begin
                r_sum   <= r_sum + {{(SUM_W-32){1'b0}}, r_prod[31:0]};
                r_first <= 1'b0;
                if (r_k != '0) begin
                    r_k <= r_k - 1'b1;
                end
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    r_noise <= w_quot;
                end
            end
            S_OUT: r_height <= w_blend;
            default: ;
        endcase
    end

    assign o_done     = r_done;
    assign o_height   = r_height;
    assign o_cell_row = r_row;
    assign o_cell_col = r_col;

endmodule

/* tb/sv/tb_fractal_value_noise_heightmap_top.sv */
// Testbench for the fractal value noise height map: checks register readback, loads grid
// samples, reads cell heights and checks each one against an in-bench octave-sum predictor.
// Depends on fvnh_pkg and fractal_value_noise_heightmap_top.
module tb_fractal_value_noise_heightmap_top;
    import fvnh_pkg::*;

    typedef struct packed {
        logic [15:0]      height;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_height_rec;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               i_command;
    logic [ROW_W-1:0]   i_row;
    logic [COL_W-1:0]   i_col;
    logic [SMP_W-1:0]   i_sample;
    logic               o_done;
    logic [15:0]        o_height;
    logic [ROW_W-1:0]   o_cell_row;
    logic [COL_W-1:0]   o_cell_col;

    // bench copy of the block state
    t_cfg        cfg_now;
    logic [15:0] grid_q16 [MEM_DEPTH];
    bit          seeded [MEM_DEPTH];
    t_height_rec heights_due [$];
    t_height_rec due;
    int          mismatches;
    int          idle_pct;
    int          items_sent;

    fractal_value_noise_heightmap_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_sample   (i_sample),
        .o_done     (o_done),
        .o_height   (o_height),
        .o_cell_row (o_cell_row),
        .o_cell_col (o_cell_col)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // ---------------- predictor ----------------

    function automatic void grid_geometry(output int nr, output int nc, output int oc);
        nr = (cfg_now.rows == 0) ? 1 : (cfg_now.rows > MAX_ROWS) ? int'(MAX_ROWS)
                                                               : int'(cfg_now.rows);
        nc = (cfg_now.cols == 0) ? 1 : (cfg_now.cols > MAX_COLS) ? int'(MAX_COLS)
                                                               : int'(cfg_now.cols);
        oc = (cfg_now.octs == 0) ? 1 : (cfg_now.octs > MAX_OCT) ? int'(MAX_OCT)
                                                              : int'(cfg_now.octs);
    endfunction

    function automatic void lattice_corners(int i, int j, int k, int nr, int nc,
                                            output int i0, output int i1,
                                            output int j0, output int j1);
        i0 = (i >> k) << k;
        i1 = (i0 + (1 << k)) % nr;
        j0 = (j >> k) << k;
        j1 = (j0 + (1 << k)) % nc;
    endfunction

    function automatic logic [63:0] mix_q16(logic [63:0] a, logic [63:0] b, logic [63:0] t);
        return (a * (64'd65536 - t) + b * t) >> 16;
    endfunction

    function automatic logic [63:0] octave_q16(int i, int j, int k, int nr, int nc);
        int i0, i1, j0, j1;
        logic [63:0] th, tv, top, bot;
        lattice_corners(i, j, k, nr, nc, i0, i1, j0, j1);
        th  = (64'(i - i0) << 16) >> k;
        tv  = (64'(j - j0) << 16) >> k;
        top = mix_q16(grid_q16[i0 * int'(MAX_COLS) + j0], grid_q16[i1 * int'(MAX_COLS) + j0], th);
        bot = mix_q16(grid_q16[i0 * int'(MAX_COLS) + j1], grid_q16[i1 * int'(MAX_COLS) + j1], th);
        return mix_q16(top, bot, tv);
    endfunction

    function automatic t_height_rec predict_height(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        int nr, nc, oc, i, j, n;
        logic [63:0] w, total, acc, noise;
        t_height_rec rec;
        grid_geometry(nr, nc, oc);
        i = int'(r) % nr;
        j = int'(c) % nc;
        w = 64'(cfg_now.pers);
        total = 0;
        acc = 0;
        // coarsest octave first; each finer one carries one more factor of persistence
        for (n = 1; n <= oc; n++) begin
            if (n > 1) w = (w * cfg_now.pers) >> 16;
            total += w;
            acc += octave_q16(i, j, oc - n, nr, nc) * w;
        end
        noise = (total != 0) ? acc / total : 64'd0;
        if (noise > 64'd65535) noise = 64'd65535;
        rec.height = 16'((64'(cfg_now.hmin) * (64'd65536 - noise)
                        + 64'(cfg_now.hmax) * noise) >> 16);
        rec.row = r;
        rec.col = c;
        return rec;
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(int idx);
        case (idx)
            REG_ROWS: return PDATA_W'(cfg_now.rows);
            REG_COLS: return PDATA_W'(cfg_now.cols);
            REG_OCTS: return PDATA_W'(cfg_now.octs);
            REG_PERS: return PDATA_W'(cfg_now.pers);
            REG_HMIN: return PDATA_W'(cfg_now.hmin);
            REG_HMAX: return PDATA_W'(cfg_now.hmax);
            default:  return '0;
        endcase
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (heights_due.size() == 0) begin
                flag_mismatch("unexpected result height", 0, o_height);
            end else begin
                due = heights_due.pop_front();
                if (o_height !== due.height) flag_mismatch("height", due.height, o_height);
                if (o_cell_row !== due.row) flag_mismatch("cell_row", due.row, o_cell_row);
                if (o_cell_col !== due.col) flag_mismatch("cell_col", due.col, o_cell_col);
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(logic cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic [SMP_W-1:0] s);
        bit taken;
        int idx;
        // idle only once the block is free, so gaps land after a busy phase
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            do @(posedge i_clk); while (busy);
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_command = cmd;
        i_row     = r;
        i_col     = c;
        i_sample  = s;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        items_sent++;
        idx = int'(r) * int'(MAX_COLS) + int'(c);
        if (cmd == CMD_LOAD) begin
            grid_q16[idx] = s;
            seeded[idx]   = 1'b1;
        end else begin
            heights_due.push_back(predict_height(r, c));
        end
    endtask

    // load every lattice corner the read will touch that holds no sample yet
    task automatic fill_corners(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        int nr, nc, oc, i, j, k, a, b, i0, i1, j0, j1;
        int rr[2];
        int cc[2];
        grid_geometry(nr, nc, oc);
        i = int'(r) % nr;
        j = int'(c) % nc;
        for (k = 0; k < oc; k++) begin
            lattice_corners(i, j, k, nr, nc, i0, i1, j0, j1);
            rr[0] = i0;
            rr[1] = i1;
            cc[0] = j0;
            cc[1] = j1;
            for (a = 0; a < 2; a++) begin
                for (b = 0; b < 2; b++) begin
                    if (!seeded[rr[a] * int'(MAX_COLS) + cc[b]]) begin
                        send_item(CMD_LOAD, ROW_W'(rr[a]), COL_W'(cc[b]), rand_sample());
                    end
                end
            end
        end
    endtask

    task automatic read_cell(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        fill_corners(r, c);
        send_item(CMD_READ, r, c, 16'($urandom));
    endtask

    // drop start and hold until no result is pending and the block is free
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (heights_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [PDATA_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx << 2);
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(int idx);
        logic [PDATA_W-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'(idx << 2);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== reg_value(idx)) flag_mismatch("register readback", reg_value(idx), got);
    endtask

    task automatic cfg_write(int idx, logic [PDATA_W-1:0] val);
        settle();
        apb_write(idx, val);
        case (idx)
            REG_ROWS: cfg_now.rows = val[DIM_W-1:0];
            REG_COLS: cfg_now.cols = val[DIM_W-1:0];
            REG_OCTS: cfg_now.octs = val[OCT_W-1:0];
            REG_PERS: cfg_now.pers = val[15:0];
            REG_HMIN: cfg_now.hmin = val[15:0];
            REG_HMAX: cfg_now.hmax = val[15:0];
            default: ;
        endcase
        check_register(idx);
    endtask

    // ---------------- tests ----------------

    task automatic test_register_reset();
        int idx;
        for (idx = REG_ROWS; idx <= REG_HMAX; idx++) check_register(idx);
    endtask

    task automatic test_grid_extremes();
        cfg_write(REG_ROWS, 4);
        cfg_write(REG_COLS, 4);
        cfg_write(REG_OCTS, 3);
        cfg_write(REG_PERS, 16'hFFFF);
        cfg_write(REG_HMIN, 0);
        cfg_write(REG_HMAX, 16'hFFFF);
        send_item(CMD_LOAD, 0, 0, 16'hFFFF);
        send_item(CMD_LOAD, 0, 1, 16'h0000);
        send_item(CMD_LOAD, 1, 0, 16'h0000);
        send_item(CMD_LOAD, 3, 3, 16'hFFFF);
        send_item(CMD_LOAD, 63, 63, 16'h8000);
        read_cell(0, 0);
        read_cell(3, 3);
        read_cell(63, 63);     // wraps onto (3, 3), echoes the given cell
        read_cell(2, 1);
    endtask

    task automatic test_special_cases();
        cfg_write(REG_PERS, 0);         // zero total weight gives min height
        read_cell(1, 2);
        cfg_write(REG_PERS, RST_PERS);
        cfg_write(REG_HMIN, 16'hFFFF);  // min above max
        cfg_write(REG_HMAX, 0);
        read_cell(2, 2);
        cfg_write(REG_OCTS, 0);         // octave count clamps up
        read_cell(3, 1);
        cfg_write(REG_OCTS, 15);        // clamps down, periods beyond the grid
        cfg_write(REG_ROWS, 0);
        cfg_write(REG_COLS, 127);
        read_cell(5, 63);
        read_cell(63, 40);
    endtask

    task automatic random_config();
        case ($urandom_range(9))
            0:       cfg_write(REG_ROWS, 1);
            1:       cfg_write(REG_ROWS, 64);
            2:       cfg_write(REG_ROWS, 0);
            3:       cfg_write(REG_ROWS, $urandom_range(65, 127));
            default: cfg_write(REG_ROWS, $urandom_range(1, 64));
        endcase
        case ($urandom_range(9))
            0:       cfg_write(REG_COLS, 1);
            1:       cfg_write(REG_COLS, 64);
            2:       cfg_write(REG_COLS, 0);
            3:       cfg_write(REG_COLS, $urandom_range(65, 127));
            default: cfg_write(REG_COLS, $urandom_range(1, 64));
        endcase
        case ($urandom_range(9))
            0:       cfg_write(REG_OCTS, 1);
            1:       cfg_write(REG_OCTS, 8);
            2:       cfg_write(REG_OCTS, 0);
            3:       cfg_write(REG_OCTS, $urandom_range(9, 15));
            default: cfg_write(REG_OCTS, $urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
            0:       cfg_write(REG_PERS, 0);
            1:       cfg_write(REG_PERS, 1);
            2:       cfg_write(REG_PERS, 16'hFFFF);
            default: cfg_write(REG_PERS, $urandom_range(1, 65535));
        endcase
        cfg_write(REG_HMIN, rand_sample());
        cfg_write(REG_HMAX, rand_sample());
    endtask

    task automatic test_random_traffic();
        int sender_idle[3];
        int phase, seg, seg_base;
        sender_idle = '{21, 68, 0};
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = sender_idle[phase];
            for (seg = 0; seg < 5; seg++) begin
                random_config();
                // count corner loads too, so the segment budget covers every transaction
                seg_base = items_sent;
                while (items_sent - seg_base < 66) begin
                    if ($urandom_range(99) < 40) begin
                        send_item(CMD_LOAD, ROW_W'($urandom), COL_W'($urandom), rand_sample());
                    end else begin
                        read_cell(ROW_W'($urandom), COL_W'($urandom));
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        i_command  = CMD_LOAD;
        i_row      = '0;
        i_col      = '0;
        i_sample   = '0;
        mismatches = 0;
        idle_pct   = 21;
        items_sent = 0;
        cfg_now.rows = RST_ROWS;
        cfg_now.cols = RST_COLS;
        cfg_now.octs = RST_OCTS;
        cfg_now.pers = RST_PERS;
        cfg_now.hmin = RST_HMIN;
        cfg_now.hmax = RST_HMAX;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_reset();
        test_grid_extremes();
        test_special_cases();
        test_random_traffic();

        settle();
        repeat (250) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/fvnh_pkg.sv
design/fvnh_regs.sv
design/fvnh_mem.sv
design/fvnh_rem.sv
design/fvnh_div.sv
design/fractal_value_noise_heightmap_top.sv
tb/sv/tb_fractal_value_noise_heightmap_top.sv
